// File: rtl/assert_macros.svh
// assertion macros used by socket_bind_table.sv
// no dependencies; included inside module bodies that reference clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked at every rising clock edge out of reset
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/sbt_pkg.sv
// types and constants of the socket bind table
// no dependencies
`timescale 1ns / 1ps
package sbt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [1:0] ACT_BIND  = 2'd0;
    localparam logic [1:0] ACT_CLOSE = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BOUND  = 2'd1;
    localparam logic [1:0] ST_IN_USE = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  socket_id;
        logic [7:0]  addr_family;
        logic [15:0] port;
        logic [31:0] ip_address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [7:0]  out_family;
        logic [15:0] out_port;
        logic [31:0] out_ip;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  socket;
        logic [7:0]  family;
        logic [15:0] port;
        logic [31:0] ip;
    } entry_t;

endpackage

// File: rtl/socket_bind_table.sv
// socket bind table: bind / close / query over a table of bound sockets
// depends on sbt_pkg and assert_macros.svh
`timescale 1ns / 1ps
// a new request can be accepted in the strobe cycle
// the cost is the scan: one entry of the table memory is read per cycle through its read port
// busy stays high from accept until the result strobe, one request at a time
// done pulses for one cycle with rsp; the receiver cannot stall it
// async active-low reset clears all valid bits, the table data stays undefined until written
module socket_bind_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sbt_pkg::req_t req,
    output logic          done,
    output sbt_pkg::rsp_t rsp
);
    import sbt_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;   // waiting for a request
    localparam logic [1:0] S_SCAN  = 2'd1;   // issuing one memory read per cycle
    localparam logic [1:0] S_DRAIN = 2'd2;   // checking the last entry read
    localparam logic [1:0] S_FIN   = 2'd3;   // decide, update table, register result

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // table data, with a write port and a registered read port
    entry_t entry_mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    // valid bits in flops so reset clears them at once
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    logic [1:0]       state_reg, state_next;
    req_t             req_reg, req_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;          // read address during the scan
    logic             chk_vld_reg, chk_vld_next;  // read data returns this cycle
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;  // index of the returning entry

    // scan results
    logic             hit_reg, hit_next;          // socket already has an entry
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    entry_t           hit_data_reg, hit_data_next;
    logic             conf_reg, conf_next;        // port / address conflict
    logic             free_reg, free_next;        // a free slot was seen
    logic [IDX_W-1:0] free_idx_reg, free_idx_next; // lowest free slot

    logic  done_reg, done_next;
    rsp_t  rsp_reg, rsp_next;

    logic  mem_we;
    logic  chk_valid;
    logic  sock_match;
    logic  port_conf;

    // compare stage on the entry that comes back from memory
    always_comb
    begin
        chk_valid  = valid_reg[chk_idx_reg];
        sock_match = chk_vld_reg && chk_valid && (rd_data_reg.socket == req_reg.socket_id);
        port_conf  = chk_vld_reg && chk_valid && (rd_data_reg.port == req_reg.port)
                     && ((rd_data_reg.ip == req_reg.ip_address) || (rd_data_reg.ip == 32'd0)
                         || (req_reg.ip_address == 32'd0));
    end

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        cnt_next      = cnt_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = cnt_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_data_next = hit_data_reg;
        conf_next     = conf_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        mem_we        = 1'b0;

        // fold the returning entry into the scan flags
        if (sock_match && !hit_reg)
        begin
            hit_next      = 1'b1;
            hit_idx_next  = chk_idx_reg;
            hit_data_next = rd_data_reg;
        end
        if (port_conf)
        begin
            conf_next = 1'b1;
        end
        if (chk_vld_reg && !chk_valid && !free_reg)
        begin
            free_next     = 1'b1;
            free_idx_next = chk_idx_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    conf_next  = 1'b0;
                    free_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                chk_vld_next = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                rsp_next   = '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
                case (req_reg.action)
                    ACT_BIND:
                    begin
                        // priority: already bound, then in use, then full
                        if (hit_reg)
                        begin
                            rsp_next.status = ST_BOUND;
                        end
                        else if (conf_reg)
                        begin
                            rsp_next.status = ST_IN_USE;
                        end
                        else if (!free_reg)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            mem_we                   = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                        end
                    end
                    ACT_CLOSE:
                    begin
                        if (hit_reg)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                        end
                    end
                    ACT_QUERY:
                    begin
                        if (hit_reg)
                        begin
                            rsp_next.found      = 1'b1;
                            rsp_next.out_family = hit_data_reg.family;
                            rsp_next.out_port   = hit_data_reg.port;
                            rsp_next.out_ip     = hit_data_reg.ip;
                        end
                    end
                    default:
                    begin
                        // unused action code: no change, zero result
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            chk_vld_reg <= 1'b0;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
        end
    end

    // payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        cnt_reg      <= cnt_next;
        chk_idx_reg  <= chk_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_data_reg <= hit_data_next;
        conf_reg     <= conf_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        rsp_reg      <= rsp_next;
    end

    // table memory: write on a successful bind, read at the scan address
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[free_idx_reg] <= '{socket: req_reg.socket_id,
                                         family: req_reg.addr_family,
                                         port:   req_reg.port,
                                         ip:     req_reg.ip_address};
        end
        rd_data_reg <= entry_mem[cnt_reg];
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`include "assert_macros.svh"

    // result strobe only once the sequencer is back in idle
    `ASSERT_IMP(a_done_idle, done, !busy)
    // an accepted request always starts the scan
    `ASSERT_NEXT(a_start_scan, start && !busy, state_reg == S_SCAN)
    // one strobe per request
    `ASSERT_NEXT(a_done_pulse, done, !done)
    // only a query can report a bound address
    `ASSERT_IMP(a_found_query, done && rsp.found, req_reg.action == ACT_QUERY)
    // a bind that reports ok leaves its slot valid
    `ASSERT_IMP(a_bind_valid, done && (req_reg.action == ACT_BIND) && (rsp.status == ST_OK),
                valid_reg[free_idx_reg])

endmodule

// File: tb/sv/tb_socket_bind_table.sv
// testbench for socket_bind_table: directed and random bind / close / query requests
// each reply is checked against a shadow copy of the bind table kept in the testbench
// depends on sbt_pkg and the socket_bind_table rtl
`timescale 1ns / 1ps
module tb_socket_bind_table;
    import sbt_pkg::*;

    // the one action code the package leaves unnamed; the block must ignore it
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    socket_bind_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the bind table, updated when a request is accepted
    logic   shadow_valid [TABLE_ENTRIES];
    entry_t shadow_entry [TABLE_ENTRIES];

    // replies still owed by the block, oldest first
    rsp_t pending_replies [$];
    rsp_t owed_reply;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // work out the reply to one request and apply it to the shadow table
    function automatic rsp_t bind_table_reply(input req_t r);
        rsp_t rep;
        int   hit;
        int   free_slot;
        bit   clash;
        rep = '0;
        hit = -1;
        free_slot = -1;
        clash = 1'b0;
        // slot already held by this socket, if any
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (hit < 0 && shadow_valid[i] && shadow_entry[i].socket == r.socket_id)
                hit = i;
        end
        case (r.action)
            ACT_BIND:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (shadow_valid[i])
                    begin
                        // same port with same address, or a wildcard on either side
                        if (shadow_entry[i].port == r.port &&
                            (shadow_entry[i].ip == r.ip_address ||
                             shadow_entry[i].ip == 32'd0 || r.ip_address == 32'd0))
                            clash = 1'b1;
                    end
                    else if (free_slot < 0)
                        free_slot = i;
                end
                // checks in priority order: already bound, in use, full
                if (hit >= 0)
                    rep.status = ST_BOUND;
                else if (clash)
                    rep.status = ST_IN_USE;
                else if (free_slot < 0)
                    rep.status = ST_FULL;
                else
                begin
                    rep.status = ST_OK;
                    shadow_valid[free_slot] = 1'b1;
                    shadow_entry[free_slot].socket = r.socket_id;
                    shadow_entry[free_slot].family = r.addr_family;
                    shadow_entry[free_slot].port = r.port;
                    shadow_entry[free_slot].ip = r.ip_address;
                end
            end
            ACT_CLOSE:
            begin
                // close of an unbound socket leaves the table alone
                if (hit >= 0)
                    shadow_valid[hit] = 1'b0;
            end
            ACT_QUERY:
            begin
                if (hit >= 0)
                begin
                    rep.found = 1'b1;
                    rep.out_family = shadow_entry[hit].family;
                    rep.out_port = shadow_entry[hit].port;
                    rep.out_ip = shadow_entry[hit].ip;
                end
            end
            default:
            begin
                // unused code: all-zero reply, table unchanged
            end
        endcase
        return rep;
    endfunction

    // drive one request at the falling edge and hold it until accepted
    task automatic send_request(input logic [1:0] act, input logic [7:0] sock,
                                input logic [7:0] fam, input logic [15:0] prt,
                                input logic [31:0] ip);
        req_t r;
        r.action = act;
        r.socket_id = sock;
        r.addr_family = fam;
        r.port = prt;
        r.ip_address = ip;
        @(negedge clk);
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_replies.push_back(bind_table_reply(r));
    endtask

    // stop sending and wait until every owed reply has come back
    task automatic wait_replies_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // each reply is checked field by field against the oldest owed reply
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
                report_error("reply with no request outstanding");
            else
            begin
                owed_reply = pending_replies.pop_front();
                if (rsp.status !== owed_reply.status)
                    report_error($sformatf("status want %0d got %0d",
                                           owed_reply.status, rsp.status));
                if (rsp.found !== owed_reply.found)
                    report_error($sformatf("found want %0d got %0d",
                                           owed_reply.found, rsp.found));
                if (rsp.out_family !== owed_reply.out_family)
                    report_error($sformatf("out_family want %h got %h",
                                           owed_reply.out_family, rsp.out_family));
                if (rsp.out_port !== owed_reply.out_port)
                    report_error($sformatf("out_port want %h got %h",
                                           owed_reply.out_port, rsp.out_port));
                if (rsp.out_ip !== owed_reply.out_ip)
                    report_error($sformatf("out_ip want %h got %h",
                                           owed_reply.out_ip, rsp.out_ip));
            end
        end
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // bind rules: extremes, already bound, wildcard on either side, close and query corners
    task automatic test_bind_rules();
        send_request(ACT_BIND,   8'd0,   8'd0,   16'd0,      32'd0);
        // bound with all-zero data still reports found
        send_request(ACT_QUERY,  8'd0,   8'hFF,  16'hFFFF,   32'hFFFF_FFFF);
        send_request(ACT_BIND,   8'd0,   8'd5,   16'd1234,   32'd7);
        // existing entry is a wildcard on port 0
        send_request(ACT_BIND,   8'd255, 8'hFF,  16'd0,      32'hFFFF_FFFF);
        send_request(ACT_CLOSE,  8'd0,   8'd0,   16'd0,      32'd0);
        // close and query of an unbound socket
        send_request(ACT_CLOSE,  8'd0,   8'hAA,  16'h5555,   32'hA5A5_A5A5);
        send_request(ACT_QUERY,  8'd0,   8'd0,   16'd0,      32'd0);
        send_request(ACT_BIND,   8'd255, 8'hFF,  16'hFFFF,   32'hFFFF_FFFF);
        // new request is the wildcard
        send_request(ACT_BIND,   8'd1,   8'd2,   16'hFFFF,   32'd0);
        // same port, different specific addresses is fine
        send_request(ACT_BIND,   8'd2,   8'd2,   16'hFFFF,   32'hFFFF_FFFE);
        // same port, same address
        send_request(ACT_BIND,   8'd3,   8'd2,   16'hFFFF,   32'hFFFF_FFFF);
        send_request(ACT_UNUSED, 8'd255, 8'hFF,  16'hFFFF,   32'hFFFF_FFFF);
        send_request(ACT_QUERY,  8'd255, 8'd0,   16'd0,      32'd0);
    endtask

    // fill the table, then check error priority on a full table and reuse of a freed slot
    task automatic test_table_full();
        for (int i = 0; i < TABLE_ENTRIES - 2; i++)
            send_request(ACT_BIND, 8'(16 + i), 8'(i), 16'(1000 + i), 32'(i + 1));
        send_request(ACT_BIND,  8'd100, 8'd9, 16'd7,    32'd9);
        // already bound wins over full
        send_request(ACT_BIND,  8'd255, 8'd9, 16'd7,    32'd9);
        // in use wins over full
        send_request(ACT_BIND,  8'd101, 8'd9, 16'hFFFF, 32'd0);
        send_request(ACT_CLOSE, 8'd2,   8'd0, 16'd0,    32'd0);
        send_request(ACT_BIND,  8'd100, 8'd9, 16'd7,    32'd9);
        send_request(ACT_QUERY, 8'd100, 8'd0, 16'd0,    32'd0);
    endtask

    // random request mix; dense draws from small pools so conflicts and a full table are common
    task automatic test_random_traffic(input int count, input bit dense);
        int          burst_left;
        int          gap;
        int          pick;
        logic [7:0]  live [$];
        logic [1:0]  act;
        logic [7:0]  sock;
        logic [15:0] prt;
        logic [31:0] ip;
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            // sender bursts with random gaps, after an opening stretch with none
            if (n >= 40 && burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0)
                begin
                    gap = $urandom_range(1, 40);
                    @(negedge clk);
                    start <= 1'b0;
                    // sometimes count the gap from the end of the current request
                    if ($urandom_range(0, 1))
                        while (busy)
                            @(negedge clk);
                    repeat (gap - 1)
                        @(negedge clk);
                end
            end
            if (burst_left > 0)
                burst_left--;

            pick = $urandom_range(0, 99);
            if (pick < 48)
                act = ACT_BIND;
            else if (pick < 72)
                act = ACT_CLOSE;
            else if (pick < 97)
                act = ACT_QUERY;
            else
                act = ACT_UNUSED;

            // close and query mostly aim at sockets that are bound right now
            live.delete();
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (shadow_valid[i])
                    live.push_back(shadow_entry[i].socket);
            end
            if (act != ACT_BIND && live.size() != 0 && $urandom_range(0, 9) < 7)
                sock = live[$urandom_range(0, live.size() - 1)];
            else if (dense && $urandom_range(0, 9) < 8)
                sock = 8'($urandom_range(0, 23));
            else
                sock = 8'($urandom_range(0, 255));

            if (dense && $urandom_range(0, 9) < 6)
            begin
                case ($urandom_range(0, 3))
                    0: prt = 16'd0;
                    1: prt = 16'd80;
                    2: prt = 16'd443;
                    default: prt = 16'hFFFF;
                endcase
            end
            else
                prt = 16'($urandom_range(0, 65535));

            pick = $urandom_range(0, 99);
            if (pick < (dense ? 25 : 10))
                ip = 32'd0;
            else if (dense && pick < 60)
                ip = $urandom_range(1, 3);
            else
                ip = $urandom();

            send_request(act, sock, 8'($urandom_range(0, 255)), prt, ip);
        end
    endtask

    initial
    begin
        // inputs known from time zero, reset asserted from time zero
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_entry[i] = '0;
        end
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bind_rules();
        wait_replies_drained();
        test_table_full();
        wait_replies_drained();
        test_random_traffic(900, 1'b1);
        // sender holds off until every owed reply has come
        wait_replies_drained();
        test_random_traffic(450, 1'b0);
        wait_replies_drained();

        // quiet tail to catch a stray reply
        repeat (TABLE_ENTRIES + 8)
            @(posedge clk);
        if (pending_replies.size() != 0)
            report_error($sformatf("%0d replies never arrived", pending_replies.size()));
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sbt_pkg.sv
rtl/socket_bind_table.sv
tb/sv/tb_socket_bind_table.sv
